// ===== rtl/core/rma_pkg.sv =====
package rma_pkg;

  localparam int COORD_W       = 20;
  localparam int NUM_COORD     = 4;
  localparam int RECT_W        = COORD_W * NUM_COORD;
  localparam int WIN_LEN_W     = 5;
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_UPD  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

endpackage

// ===== rtl/core/rma_div_serial.sv =====
module rma_div_serial #(
  parameter int SUMW = 24,
  parameter int CNTW = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUMW-1:0]            dividend,
  input  logic        [CNTW-1:0]            divisor,
  output logic                              busy,
  output logic signed [rma_pkg::COORD_W-1:0] quotient
);

  localparam int CW = $clog2(SUMW + 1);

  logic [CW-1:0]   count_r, count_nxt;
  logic [SUMW-1:0] quo_r, quo_nxt;
  logic [CNTW-1:0] rem_r, rem_nxt;
  logic [CNTW-1:0] div_r;
  logic            neg_r;
  logic [CNTW:0]   shifted;
  logic [CNTW:0]   sub;
  logic            ge;
  logic [SUMW-1:0] quo_signed;

  assign busy    = (count_r != '0);
  assign shifted = {rem_r, quo_r[SUMW-1]};
  assign ge      = (shifted >= {1'b0, div_r});
  assign sub     = shifted - {1'b0, div_r};

  always_comb begin
    count_nxt = count_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    if (start) begin
      count_nxt = CW'(SUMW);
      quo_nxt   = dividend[SUMW-1] ? (~dividend + SUMW'(1)) : dividend;
      rem_nxt   = '0;
    end else if (busy) begin
      count_nxt = count_r - CW'(1);
      quo_nxt   = {quo_r[SUMW-2:0], ge};
      rem_nxt   = ge ? sub[CNTW-1:0] : shifted[CNTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
      neg_r <= dividend[SUMW-1];
    end
  end

  // sign restored on the magnitude quotient: truncation toward zero
  assign quo_signed = neg_r ? (~quo_r + SUMW'(1)) : quo_r;
  assign quotient   = quo_signed[rma_pkg::COORD_W-1:0];

endmodule

// ===== rtl/core/rect_moving_average_top.sv =====
// Moving average of rectangles (four signed Q16.4 corner coordinates). Each
// request is stored in a ring of up to WINDOW_MAX entries and one result, the
// per-coordinate mean over the entries held so far (truncated toward zero),
// comes back for it. Requests are handled one at a time: a new request is
// taken only once the result of the last one is loaded into the output
// register. A restoring divider produces one quotient bit per cycle, four
// coordinate lanes in parallel. A finished result waits in the output
// register while the next request is taken. The ring has no clearing pass;
// entries are read only once written. window_length is taken as 1 when 0
// and as WINDOW_MAX when larger; write it only while idle.
module rect_moving_average_top #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // left_x, top_y, right_x, bottom_y (20 bits each, lowest first)
  input  logic [rma_pkg::RECT_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // mean_left_x, mean_top_y, mean_right_x, mean_bottom_y (20 bits each)
  output logic [rma_pkg::RECT_W-1:0]  out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [rma_pkg::WIN_LEN_W-1:0] cfg_wr_data
);

  localparam int CW   = rma_pkg::COORD_W;
  localparam int NC   = rma_pkg::NUM_COORD;
  localparam int RW   = rma_pkg::RECT_W;
  localparam int CNTW = $clog2(WINDOW_MAX + 1);
  localparam int IDXW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUMW = CW + $clog2(WINDOW_MAX);
  localparam int CMPW = (CNTW > rma_pkg::WIN_LEN_W) ? CNTW : rma_pkg::WIN_LEN_W;

  rma_pkg::state_t state_r, state_nxt;

  logic [rma_pkg::WIN_LEN_W-1:0] window_length_r;
  logic [CNTW-1:0]               fill_count_r, fill_count_nxt;
  logic [IDXW-1:0]               write_slot_r, write_slot_nxt;
  logic [IDXW-1:0]               slot_r, slot_nxt;
  logic                          append_r, append_nxt;
  logic [RW-1:0]                 in_rect_r;
  logic [RW-1:0]                 old_rect_r;
  logic [RW-1:0]                 ring_mem [WINDOW_MAX];
  logic signed [SUMW-1:0]        sum_r   [NC];
  logic signed [SUMW-1:0]        sum_nxt [NC];
  logic signed [CW-1:0]          quo     [NC];
  logic [NC-1:0]                 div_busy;
  logic                          div_start;
  logic                          in_req;
  logic                          out_load;
  logic                          out_tvalid_r;
  logic [RW-1:0]                 out_tdata_r;

  logic [CMPW-1:0] win_ext, fill_ext, eff_win;
  logic [CNTW-1:0] slot_inc;

  assign in_tready  = (state_r == rma_pkg::ST_IDLE);
  assign in_req     = in_tvalid && in_tready;
  assign div_start  = (state_r == rma_pkg::ST_UPD);
  assign out_load   = (state_r == rma_pkg::ST_DIV) && (div_busy == '0) &&
                      (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    win_ext  = CMPW'(window_length_r);
    fill_ext = CMPW'(fill_count_r);
    if (win_ext == '0) begin
      eff_win = CMPW'(1);
    end else if (win_ext > CMPW'(WINDOW_MAX)) begin
      eff_win = CMPW'(WINDOW_MAX);
    end else begin
      eff_win = win_ext;
    end
    append_nxt = (fill_ext < eff_win);
    if (append_nxt) begin
      slot_nxt = IDXW'(fill_count_r);
    end else if (CNTW'(write_slot_r) < fill_count_r) begin
      slot_nxt = write_slot_r;
    end else begin
      slot_nxt = '0;
    end
  end

  assign slot_inc = CNTW'(slot_r) + CNTW'(1);

  always_comb begin
    fill_count_nxt = fill_count_r;
    write_slot_nxt = write_slot_r;
    if (div_start) begin
      if (append_r) begin
        fill_count_nxt = fill_count_r + CNTW'(1);
      end else begin
        write_slot_nxt = (slot_inc < fill_count_r) ? IDXW'(slot_inc) : '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sum_nxt[k] = sum_r[k] + SUMW'(signed'(in_rect_r[k*CW +: CW]));
      if (!append_r) begin
        sum_nxt[k] = sum_nxt[k] - SUMW'(signed'(old_rect_r[k*CW +: CW]));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rma_pkg::ST_IDLE: if (in_req) state_nxt = rma_pkg::ST_UPD;
      rma_pkg::ST_UPD:  state_nxt = rma_pkg::ST_DIV;
      rma_pkg::ST_DIV:  if (out_load) state_nxt = rma_pkg::ST_IDLE;
      default:          state_nxt = rma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= rma_pkg::ST_IDLE;
      window_length_r <= rma_pkg::WIN_LEN_RESET;
      fill_count_r    <= '0;
      write_slot_r    <= '0;
      out_tvalid_r    <= 1'b0;
      for (int k = 0; k < NC; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      write_slot_r <= write_slot_nxt;
      if (cfg_wr_en) begin
        window_length_r <= cfg_wr_data;
      end
      if (div_start) begin
        for (int k = 0; k < NC; k++) begin
          sum_r[k] <= sum_nxt[k];
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      in_rect_r  <= in_tdata;
      slot_r     <= slot_nxt;
      append_r   <= append_nxt;
      old_rect_r <= ring_mem[slot_nxt];
    end
    if (div_start) begin
      ring_mem[slot_r] <= in_rect_r;
    end
    if (out_load) begin
      for (int k = 0; k < NC; k++) begin
        out_tdata_r[k*CW +: CW] <= quo[k];
      end
    end
  end

  for (genvar g = 0; g < NC; g++) begin : g_lane
    rma_div_serial #(
      .SUMW (SUMW),
      .CNTW (CNTW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (sum_nxt[g]),
      .divisor  (fill_count_nxt),
      .busy     (div_busy[g]),
      .quotient (quo[g])
    );
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNTW'(WINDOW_MAX))
    else $error("fill count above ring depth");

  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r != '0) |-> (CNTW'(write_slot_r) < fill_count_r))
    else $error("write slot outside filled entries");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rma_pkg::ST_DIV) |-> (fill_count_r != '0))
    else $error("divide by zero fill count");

  a_lanes_lock: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (div_busy == '1))
    else $error("divider lanes out of step");

endmodule
